// File: rtl/eiupl_pkg.sv
// shared types and codes for the ethernet/ip/udp payload locator
// no dependencies; imported by every module of the block
`default_nettype none

package eiupl_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 65536;

    localparam int UDP_W    = 16;
    localparam int DNS_W    = 17;
    localparam int STATUS_W = 3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_V4_UDP       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_V6_UDP       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OTHER_TYPE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_LINK     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_V6_BAD_HDR   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_V6_CHAIN_TRC = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FIELDS_TRC   = 3'd6;

    // ethertypes
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;

    // ipv6 next header codes
    localparam logic [7:0] NH_HOP_BY_HOP = 8'd0;
    localparam logic [7:0] NH_UDP        = 8'd17;
    localparam logic [7:0] NH_ROUTING    = 8'd43;
    localparam logic [7:0] NH_FRAGMENT   = 8'd44;
    localparam logic [7:0] NH_AUTH       = 8'd51;
    localparam logic [7:0] NH_DEST_OPTS  = 8'd60;

    typedef struct packed {
        logic       last_byte;
        logic [7:0] frame_byte;
    } in_item_t;

    typedef struct packed {
        logic [DNS_W-1:0]    dns_offset;
        logic [UDP_W-1:0]    udp_offset;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/eiupl_in_stage.sv
// input register for the frame byte stream
// uses eiupl_pkg for the item type
`default_nettype none

module eiupl_in_stage (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [7:0] frame_byte
    input  wire logic               s_tlast,   // last_byte
    input  wire logic               take,
    output logic                    item_valid,
    output eiupl_pkg::in_item_t     item
);
    import eiupl_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.frame_byte <= s_tdata;
            item_reg.last_byte  <= s_tlast;
        end
    end

endmodule

`default_nettype wire

// File: rtl/eiupl_parser.sv
// per-byte header walk: ethertype, ipv4 ihl, ipv6 extension header chain
// uses eiupl_pkg for codes and types; holds the link type register
`default_nettype none

module eiupl_parser #(
    parameter int MAX_FRAME_BYTES = eiupl_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic                cfg_wdata,
    input  wire logic                advance,
    input  wire eiupl_pkg::in_item_t item,
    output eiupl_pkg::result_t       result
);
    import eiupl_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    // a header start can pass the frame limit by one maximal header
    localparam int EXT_W = $clog2(MAX_FRAME_BYTES + 2056 + 1);

    typedef enum logic [2:0] {
        PH_ETH, PH_V4, PH_V6, PH_CHAIN, PH_CHAIN_LEN, PH_DONE
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [7:0]          type_high_reg, type_high_next;
    logic [7:0]          pending_nh_reg, pending_nh_next;
    logic [7:0]          staged_nh_reg, staged_nh_next;
    logic [EXT_W-1:0]    ext_start_reg, ext_start_next;
    logic [UDP_W-1:0]    found_udp_reg, found_udp_next;
    logic [STATUS_W-1:0] latched_status_reg, latched_status_next;
    logic                link_is_ethernet_reg;

    logic [16:0]         pos17;
    logic [EXT_W-1:0]    pos_x;
    logic [7:0]          b;
    logic [STATUS_W-1:0] res_status;
    logic [UDP_W-1:0]    res_udp;

    function automatic logic is_ext_header(input logic [7:0] nh);
        return nh == NH_HOP_BY_HOP || nh == NH_ROUTING || nh == NH_DEST_OPTS ||
               nh == NH_FRAGMENT || nh == NH_AUTH;
    endfunction

    assign pos17 = 17'(pos_reg);
    assign pos_x = EXT_W'(pos_reg);
    assign b     = item.frame_byte;

    always_comb begin
        phase_next          = phase_reg;
        pos_next            = pos_reg;
        type_high_next      = type_high_reg;
        pending_nh_next     = pending_nh_reg;
        staged_nh_next      = staged_nh_reg;
        ext_start_next      = ext_start_reg;
        found_udp_next      = found_udp_reg;
        latched_status_next = latched_status_reg;

        if (pos_reg != POS_W'(MAX_FRAME_BYTES)) begin
            pos_next = pos_reg + POS_W'(1);
            unique case (phase_reg)
                PH_ETH: begin
                    if (pos17 == 17'd12) begin
                        type_high_next = b;
                    end else if (pos17 == 17'd13) begin
                        if ({type_high_reg, b} == ETH_IPV4) begin
                            phase_next = PH_V4;
                        end else if ({type_high_reg, b} == ETH_IPV6) begin
                            phase_next = PH_V6;
                        end else begin
                            latched_status_next = ST_OTHER_TYPE;
                            found_udp_next      = '0;
                            phase_next          = PH_DONE;
                        end
                    end
                end
                PH_V4: begin
                    if (pos17 == 17'd14) begin
                        latched_status_next = ST_V4_UDP;
                        found_udp_next      = 16'd14 + {10'd0, b[3:0], 2'b00};
                        phase_next          = PH_DONE;
                    end
                end
                PH_V6: begin
                    if (pos17 == 17'd20) begin
                        if (b == NH_UDP) begin
                            latched_status_next = ST_V6_UDP;
                            found_udp_next      = 16'd54;
                            phase_next          = PH_DONE;
                        end else if (is_ext_header(b)) begin
                            pending_nh_next = b;
                            ext_start_next  = EXT_W'(54);
                            phase_next      = PH_CHAIN;
                        end else begin
                            latched_status_next = ST_V6_BAD_HDR;
                            found_udp_next      = '0;
                            phase_next          = PH_DONE;
                        end
                    end
                end
                PH_CHAIN: begin
                    if (pos_x == ext_start_reg) begin
                        if (pending_nh_reg == NH_UDP) begin
                            latched_status_next = ST_V6_UDP;
                            found_udp_next      = pos17[15:0];
                            phase_next          = PH_DONE;
                        end else if (is_ext_header(pending_nh_reg)) begin
                            staged_nh_next = b;
                            phase_next     = PH_CHAIN_LEN;
                        end else begin
                            latched_status_next = ST_V6_BAD_HDR;
                            found_udp_next      = '0;
                            phase_next          = PH_DONE;
                        end
                    end
                end
                PH_CHAIN_LEN: begin
                    if (pending_nh_reg == NH_FRAGMENT) begin
                        if (pos_x == ext_start_reg + EXT_W'(7)) begin
                            ext_start_next  = ext_start_reg + EXT_W'(8);
                            pending_nh_next = staged_nh_reg;
                            phase_next      = PH_CHAIN;
                        end
                    end else if (pos_x == ext_start_reg + EXT_W'(1)) begin
                        if (pending_nh_reg == NH_AUTH) begin
                            ext_start_next = ext_start_reg +
                                             EXT_W'({9'(b) + 9'd2, 2'b00});
                        end else begin
                            ext_start_next = ext_start_reg +
                                             EXT_W'({9'(b) + 9'd1, 3'b000});
                        end
                        pending_nh_next = staged_nh_reg;
                        phase_next      = PH_CHAIN;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase
        end

        // frame end verdict
        if (!link_is_ethernet_reg) begin
            res_status = ST_BAD_LINK;
            res_udp    = '0;
        end else if (phase_next == PH_DONE) begin
            res_status = latched_status_next;
            res_udp    = found_udp_next;
        end else if (phase_next == PH_CHAIN || phase_next == PH_CHAIN_LEN) begin
            res_status = ST_V6_CHAIN_TRC;
            res_udp    = '0;
        end else begin
            res_status = ST_FIELDS_TRC;
            res_udp    = '0;
        end
        result.status = res_status;
        if (res_status == ST_V4_UDP || res_status == ST_V6_UDP) begin
            result.udp_offset = res_udp;
            result.dns_offset = 17'(res_udp) + 17'd8;
        end else begin
            result.udp_offset = '0;
            result.dns_offset = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_is_ethernet_reg <= 1'b1;
        end else if (cfg_we) begin
            link_is_ethernet_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && item.last_byte)) begin
            phase_reg          <= PH_ETH;
            pos_reg            <= '0;
            type_high_reg      <= '0;
            pending_nh_reg     <= '0;
            staged_nh_reg      <= '0;
            ext_start_reg      <= '0;
            found_udp_reg      <= '0;
            latched_status_reg <= ST_FIELDS_TRC;
        end else if (advance) begin
            phase_reg          <= phase_next;
            pos_reg            <= pos_next;
            type_high_reg      <= type_high_next;
            pending_nh_reg     <= pending_nh_next;
            staged_nh_reg      <= staged_nh_next;
            ext_start_reg      <= ext_start_next;
            found_udp_reg      <= found_udp_next;
            latched_status_reg <= latched_status_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/eiupl_out_stage.sv
// result register driving the master side
// uses eiupl_pkg for the result type
`default_nettype none

module eiupl_out_stage (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire eiupl_pkg::result_t result,
    output logic                    out_free,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [39:0]             m_tdata   // [2:0] status, [18:3] udp_offset,
                                              // [35:19] dns_offset
);
    import eiupl_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, result_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ethernet_ip_udp_payload_locator_core.sv
// top level of the ethernet/ip/udp payload locator
// uses eiupl_pkg, eiupl_in_stage, eiupl_parser and eiupl_out_stage
//
// usage:
//   s_ carries frame bytes in order from the ethernet header, s_tlast on the
//   last byte of each frame. every request with s_tlast high yields exactly
//   one request on m_: status, udp offset and dns payload offset.
//   cfg_we/cfg_wdata write link_is_ethernet (reset 1) while the block is idle.
//   throughput is one byte per cycle unless a last byte waits on a full
//   output register; each byte is parsed between the input register and
//   the parser state, and the result goes to the output register in the
//   same step. m_tvalid comes from the output register, behind the input one.
//   if m_ stalls, one result waits in the output register while further
//   bytes of the next frame keep flowing; s_tready drops only when a last
//   byte finds the output register still full.
//   synchronous active-low reset empties both registers, sets the link type
//   to ethernet and starts a fresh frame.
`default_nettype none

module ethernet_ip_udp_payload_locator_core #(
    parameter int MAX_FRAME_BYTES = eiupl_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,  // link_is_ethernet
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] frame_byte
    input  wire logic        s_tlast,    // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata     // [2:0] status, [18:3] udp_offset,
                                         // [35:19] dns_offset
);
    import eiupl_pkg::*;

    logic     item_valid;
    in_item_t item;
    logic     out_free;
    logic     advance;
    logic     load;
    result_t  result;

    assign advance = item_valid && (!item.last_byte || out_free);
    assign load    = advance && item.last_byte;

    eiupl_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    eiupl_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .item      (item),
        .result    (result)
    );

    eiupl_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_tvalid)
        else $error("frame end did not reach the output register");

    a_request_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> item_valid)
        else $error("accepted byte lost at the input register");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !load)
        else $error("pending result overwritten");

    a_dns_follows_udp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[2:0] == ST_V4_UDP || m_tdata[2:0] == ST_V6_UDP))
        |-> (m_tdata[35:19] == 17'(m_tdata[18:3]) + 17'd8))
        else $error("dns offset does not follow udp offset");
`endif

endmodule

`default_nettype wire

// File: bench/ethernet_ip_udp_payload_locator_core_test.sv
// self-checking bench for ethernet_ip_udp_payload_locator_core: directed and random
// frames are streamed in, and each located payload is compared with a local model
// depends on eiupl_pkg and the core rtl
module ethernet_ip_udp_payload_locator_core_test;
    import eiupl_pkg::*;

    localparam int FRAME_LIMIT   = MAX_FRAME_BYTES_DEF;
    localparam int RANDOM_BYTES  = 1650;
    localparam int RANDOM_FRAMES = 60;
    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 30;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 20;

    typedef enum logic [2:0] {
        WALK_ETH, WALK_V4, WALK_V6, WALK_CHAIN, WALK_CHAIN_LEN, WALK_DONE
    } walk_phase_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;  // [7:0] frame_byte
    logic        s_tlast   = 1'b0;  // last_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;           // [2:0] status, [18:3] udp_offset, [35:19] dns_offset

    ethernet_ip_udp_payload_locator_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    in_item_t   byte_queue[$];
    result_t    expected_locations[$];
    logic [7:0] frame_buf[$];
    logic [7:0] chain_code[$];
    logic [7:0] chain_len[$];

    in_item_t next_in;
    in_item_t drv_item;
    result_t  seen_loc;
    result_t  want_loc;
    logic     in_fire       = 1'b0;
    int       errors        = 0;
    int       results_seen  = 0;
    int       idle_cycles   = 0;
    int       random_bytes  = 0;
    int       random_frames = 0;
    int       send_gap      = 0;
    int       send_calm     = 0;
    int       recv_gap      = 0;
    int       recv_calm     = 0;
    int       hold_left     = 0;
    bit       held_off      = 1'b0;

    logic                link_ethernet;
    logic [16:0]         byte_pos;
    walk_phase_t         walk_phase;
    logic [7:0]          type_high;
    logic [7:0]          pending_nh;
    logic [7:0]          staged_nh;
    logic [16:0]         hdr_start;
    logic [16:0]         udp_found;
    logic [STATUS_W-1:0] status_found;

    function automatic bit is_ext_header(input logic [7:0] nh);
        return nh == NH_HOP_BY_HOP || nh == NH_ROUTING || nh == NH_DEST_OPTS ||
               nh == NH_FRAGMENT || nh == NH_AUTH;
    endfunction

    function automatic void clear_frame_state();
        byte_pos     = '0;
        walk_phase   = WALK_ETH;
        type_high    = '0;
        pending_nh   = '0;
        staged_nh    = '0;
        hdr_start    = '0;
        udp_found    = '0;
        status_found = ST_FIELDS_TRC;
    endfunction

    function automatic void settle(input logic [STATUS_W-1:0] st, input logic [16:0] udp);
        status_found = st;
        udp_found    = udp;
        walk_phase   = WALK_DONE;
    endfunction

    function automatic void parse_frame_byte(input logic [7:0] b);
        case (walk_phase)
            WALK_ETH: begin
                if (byte_pos == 17'd12) begin
                    type_high = b;
                end else if (byte_pos == 17'd13) begin
                    if ({type_high, b} == ETH_IPV4) walk_phase = WALK_V4;
                    else if ({type_high, b} == ETH_IPV6) walk_phase = WALK_V6;
                    else settle(ST_OTHER_TYPE, '0);
                end
            end
            WALK_V4: begin
                if (byte_pos == 17'd14) settle(ST_V4_UDP, 17'd14 + ({13'd0, b[3:0]} << 2));
            end
            WALK_V6: begin
                if (byte_pos == 17'd20) begin
                    if (b == NH_UDP) begin
                        settle(ST_V6_UDP, 17'd54);
                    end else if (is_ext_header(b)) begin
                        pending_nh = b;
                        hdr_start  = 17'd54;
                        walk_phase = WALK_CHAIN;
                    end else begin
                        settle(ST_V6_BAD_HDR, '0);
                    end
                end
            end
            WALK_CHAIN: begin
                if (byte_pos == hdr_start) begin
                    if (pending_nh == NH_UDP) begin
                        settle(ST_V6_UDP, byte_pos);
                    end else if (is_ext_header(pending_nh)) begin
                        staged_nh  = b;
                        walk_phase = WALK_CHAIN_LEN;
                    end else begin
                        settle(ST_V6_BAD_HDR, '0);
                    end
                end
            end
            WALK_CHAIN_LEN: begin
                if (pending_nh == NH_FRAGMENT) begin
                    if (byte_pos == hdr_start + 17'd7) begin
                        hdr_start  = hdr_start + 17'd8;
                        pending_nh = staged_nh;
                        walk_phase = WALK_CHAIN;
                    end
                end else if (byte_pos == hdr_start + 17'd1) begin
                    if (pending_nh == NH_AUTH) hdr_start = hdr_start + (({9'd0, b} + 17'd2) << 2);
                    else hdr_start = hdr_start + (({9'd0, b} + 17'd1) << 3);
                    pending_nh = staged_nh;
                    walk_phase = WALK_CHAIN;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void locate_payload(input in_item_t item);
        result_t             loc;
        logic [STATUS_W-1:0] st;
        logic [16:0]         udp;
        if (byte_pos < FRAME_LIMIT) begin
            parse_frame_byte(item.frame_byte);
            byte_pos = byte_pos + 17'd1;
        end
        if (item.last_byte) begin
            udp = '0;
            if (!link_ethernet) begin
                st = ST_BAD_LINK;
            end else if (walk_phase == WALK_DONE) begin
                st  = status_found;
                udp = udp_found;
            end else if (walk_phase == WALK_CHAIN || walk_phase == WALK_CHAIN_LEN) begin
                st = ST_V6_CHAIN_TRC;
            end else begin
                st = ST_FIELDS_TRC;
            end
            if (st != ST_V4_UDP && st != ST_V6_UDP) udp = '0;
            loc.status     = st;
            loc.udp_offset = udp[UDP_W-1:0];
            loc.dns_offset = (st == ST_V4_UDP || st == ST_V6_UDP) ? udp + 17'd8 : '0;
            expected_locations.push_back(loc);
            clear_frame_state();
        end
    endfunction

    function automatic int draw_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // sampling, prediction, checking and watchdog
    always @(posedge aclk) begin
        in_fire <= s_tvalid && s_tready;
        if (!aresetn) begin
            link_ethernet = 1'b1;
            clear_frame_state();
        end else begin
            if (m_tvalid && m_tready) begin
                seen_loc = m_tdata[35:0];
                results_seen++;
                if (expected_locations.size() == 0) begin
                    $error("unexpected result: status %0d udp_offset %0d dns_offset %0d",
                           seen_loc.status, seen_loc.udp_offset, seen_loc.dns_offset);
                    errors++;
                end else begin
                    want_loc = expected_locations.pop_front();
                    if (seen_loc.status !== want_loc.status) begin
                        $error("status expected %0d actual %0d", want_loc.status, seen_loc.status);
                        errors++;
                    end
                    if (seen_loc.udp_offset !== want_loc.udp_offset) begin
                        $error("udp_offset expected %0d actual %0d",
                               want_loc.udp_offset, seen_loc.udp_offset);
                        errors++;
                    end
                    if (seen_loc.dns_offset !== want_loc.dns_offset) begin
                        $error("dns_offset expected %0d actual %0d",
                               want_loc.dns_offset, seen_loc.dns_offset);
                        errors++;
                    end
                end
            end
            if (cfg_we) link_ethernet = cfg_wdata;
            if (s_tvalid && s_tready) begin
                next_in.frame_byte = s_tdata;
                next_in.last_byte  = s_tlast;
                locate_payload(next_in);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("ethernet_ip_udp_payload_locator_core_test NOT OK");
                $finish;
            end
        end
    end

    // byte driver
    always @(negedge aclk) begin
        if (aresetn && !(s_tvalid && !in_fire)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (byte_queue.size() != 0) begin
                drv_item = byte_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= drv_item.frame_byte;
                s_tlast  <= drv_item.last_byte;
                if (send_calm > 0) send_calm--;
                else if ($urandom_range(0, 199) == 0) send_calm = $urandom_range(50, 150);
                send_gap = draw_gap(send_calm > 0);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off to back the block up
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!held_off && results_seen >= HOLD_AFTER) begin
            held_off  = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (recv_calm > 0) recv_calm--;
            else if ($urandom_range(0, 199) == 0) recv_calm = $urandom_range(50, 150);
            recv_gap = draw_gap(recv_calm > 0);
        end
    end

    task automatic fill_frame(input int n);
        logic [7:0] v;
        frame_buf.delete();
        repeat (n) begin
            v = 8'($urandom);
            frame_buf.push_back(v);
        end
    endtask

    task automatic poke(input int idx, input logic [7:0] v);
        if (idx < frame_buf.size()) frame_buf[idx] = v;
    endtask

    task automatic set_type(input logic [15:0] et);
        poke(12, et[15:8]);
        poke(13, et[7:0]);
    endtask

    task automatic send_frame();
        in_item_t it;
        foreach (frame_buf[i]) begin
            it.frame_byte = frame_buf[i];
            it.last_byte  = (i == frame_buf.size() - 1);
            byte_queue.push_back(it);
        end
    endtask

    task automatic hdr(input logic [7:0] code, input logic [7:0] len);
        chain_code.push_back(code);
        chain_len.push_back(len);
    endtask

    function automatic int header_bytes(input logic [7:0] code, input logic [7:0] len);
        if (code == NH_FRAGMENT) return 8;
        if (code == NH_AUTH) return (len + 2) * 4;
        return (len + 1) * 8;
    endfunction

    function automatic int chain_span();
        int p;
        p = 54;
        foreach (chain_code[i]) p += header_bytes(chain_code[i], chain_len[i]);
        return p;
    endfunction

    // ipv6 frame carrying the queued extension chain, ending in final_nh
    task automatic build_v6(input int total, input logic [7:0] final_nh);
        int p;
        fill_frame(total);
        set_type(ETH_IPV6);
        poke(20, chain_code.size() != 0 ? chain_code[0] : final_nh);
        p = 54;
        foreach (chain_code[i]) begin
            poke(p, (i + 1 < chain_code.size()) ? chain_code[i + 1] : final_nh);
            if (chain_code[i] != NH_FRAGMENT) poke(p + 1, chain_len[i]);
            p += header_bytes(chain_code[i], chain_len[i]);
        end
        send_frame();
        chain_code.delete();
        chain_len.delete();
    endtask

    function automatic logic [7:0] pick_ext();
        case ($urandom_range(0, 4))
            0: return NH_HOP_BY_HOP;
            1: return NH_ROUTING;
            2: return NH_DEST_OPTS;
            3: return NH_FRAGMENT;
            default: return NH_AUTH;
        endcase
    endfunction

    task automatic random_frame();
        int         kind;
        int         span;
        int         total;
        logic [7:0] len;
        logic [7:0] any_nh;
        logic [15:0] any_type;
        kind     = $urandom_range(0, 99);
        any_nh   = 8'($urandom);
        any_type = 16'($urandom);
        if (kind < 30) begin
            fill_frame($urandom_range(15, 40));
            set_type(ETH_IPV4);
            send_frame();
        end else if (kind < 70) begin
            repeat ($urandom_range(0, 3)) begin
                len = ($urandom_range(0, 99) < 90) ? 8'($urandom_range(0, 3))
                                                   : 8'($urandom_range(4, 40));
                hdr(pick_ext(), len);
            end
            span = chain_span();
            if ($urandom_range(0, 99) < 15) total = $urandom_range(1, span + 1);
            else total = span + $urandom_range(0, 12);
            build_v6(total, ($urandom_range(0, 99) < 88) ? NH_UDP : any_nh);
        end else if (kind < 80) begin
            fill_frame($urandom_range(14, 30));
            set_type(any_type);
            send_frame();
        end else if (kind < 90) begin
            fill_frame($urandom_range(1, 70));
            send_frame();
        end else begin
            fill_frame($urandom_range(1, 21));
            set_type(kind[0] ? ETH_IPV4 : ETH_IPV6);
            send_frame();
        end
        random_bytes += frame_buf.size();
        random_frames++;
    endtask

    task automatic wait_idle();
        while (byte_queue.size() != 0 || s_tvalid || expected_locations.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_link(input logic value);
        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_link(1'b1);
        // short frames and the field extremes
        fill_frame(1);
        send_frame();
        fill_frame(13);
        set_type(ETH_IPV4);
        send_frame();
        fill_frame(14);
        set_type(ETH_IPV4);
        send_frame();
        fill_frame(15);
        set_type(ETH_IPV4);
        poke(14, 8'h40);
        send_frame();
        fill_frame(30);
        set_type(ETH_IPV4);
        poke(14, 8'hFF);
        send_frame();
        fill_frame(20);
        set_type(16'h0000);
        send_frame();
        fill_frame(14);
        set_type(16'hFFFF);
        send_frame();
        fill_frame(20);
        set_type(16'h86DE);
        send_frame();
        build_v6(20, NH_UDP);
        build_v6(21, NH_UDP);
        build_v6(60, 8'd6);
        build_v6(30, 8'hFF);
        // every extension header, udp start at and just before frame end
        hdr(NH_HOP_BY_HOP, 8'd0);
        build_v6(chain_span() + 8, NH_UDP);
        hdr(NH_ROUTING, 8'd2);
        hdr(NH_DEST_OPTS, 8'd1);
        hdr(NH_FRAGMENT, 8'd0);
        hdr(NH_AUTH, 8'd0);
        build_v6(chain_span(), NH_UDP);
        hdr(NH_AUTH, 8'd255);
        hdr(NH_HOP_BY_HOP, 8'd255);
        build_v6(chain_span() + 1, NH_UDP);
        // unsupported header deep in the chain, chains cut short
        hdr(NH_HOP_BY_HOP, 8'd0);
        build_v6(chain_span() + 4, 8'd59);
        hdr(NH_HOP_BY_HOP, 8'd0);
        build_v6(55, NH_UDP);
        hdr(NH_FRAGMENT, 8'd0);
        build_v6(61, NH_UDP);
        hdr(NH_FRAGMENT, 8'd0);
        build_v6(62, NH_UDP);
        hdr(NH_DEST_OPTS, 8'd0);
        build_v6(56, NH_UDP);
        // back-to-back end marks
        fill_frame(1);
        send_frame();
        fill_frame(1);
        send_frame();

        write_link(1'b0);
        fill_frame(30);
        set_type(ETH_IPV4);
        send_frame();
        repeat (7) random_frame();

        write_link(1'b1);
        random_bytes  = 0;
        random_frames = 0;
        while (random_bytes < RANDOM_BYTES || random_frames < RANDOM_FRAMES) random_frame();

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (errors == 0) begin
            $display("ethernet_ip_udp_payload_locator_core_test OK");
        end else begin
            $display("ethernet_ip_udp_payload_locator_core_test NOT OK");
        end
        $finish;
    end

endmodule
